// ===== rtl/playfair_cipher_encrypt_defines.svh =====
// Assertion macros for the Playfair encryptor port checker.
// No dependencies; include by bare file name.
`ifndef PLAYFAIR_CIPHER_ENCRYPT_DEFINES_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/pfe_pkg.sv =====
// Shared types, constants and letter/cell helper functions for the Playfair encryptor.
// No dependencies.
`timescale 1ns / 1ps
package pfe_pkg;

  localparam int SIDE         = 5;
  localparam int CELLS        = SIDE * SIDE;
  localparam int LETTER_COUNT = 26;

  localparam logic [4:0] LETTER_A = 5'd0;
  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;

  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_DONE = 2'd1;
  localparam logic [1:0] OP_PAIR = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] letter_a;
    logic [4:0] letter_b;
    logic       has_second;
  } pfe_in_t;

  typedef struct packed {
    logic [4:0] cipher_a;
    logic [4:0] cipher_b;
  } pfe_out_t;

  // Requests from the sequencer to the key store.
  typedef struct packed {
    logic       place;
    logic [4:0] letter;
    logic [4:0] place_addr;
    logic [4:0] cell_addr;
  } pfe_store_req_t;

  function automatic logic [4:0] pfe_key_letter(input logic [4:0] l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  function automatic logic [4:0] pfe_pair_letter(input logic [4:0] l);
    logic [4:0] v;
    v = (l > LETTER_Z) ? LETTER_X : l;
    return pfe_key_letter(v);
  endfunction

  function automatic logic [2:0] pfe_row(input logic [4:0] p);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 1; k < SIDE; k++) begin
      if (p >= 5'(k * SIDE)) r = 3'(k);
    end
    return r;
  endfunction

  function automatic logic [4:0] pfe_cell(input logic [2:0] r, input logic [2:0] c);
    return 5'(r * SIDE) + {2'b00, c};
  endfunction

  function automatic logic [2:0] pfe_col(input logic [4:0] p);
    logic [4:0] d;
    d = p - pfe_cell(pfe_row(p), 3'd0);
    return d[2:0];
  endfunction

  function automatic logic [2:0] pfe_next(input logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  // Cell that the letter at position p turns into, given its partner at q.
  function automatic logic [4:0] pfe_target(input logic [4:0] p, input logic [4:0] q);
    logic [2:0] rp;
    logic [2:0] cp;
    logic [2:0] rq;
    logic [2:0] cq;
    logic [4:0] idx;
    rp = pfe_row(p);
    cp = pfe_col(p);
    rq = pfe_row(q);
    cq = pfe_col(q);
    if (rp == rq) begin
      idx = pfe_cell(rp, pfe_next(cp));
    end else if (cp == cq) begin
      idx = pfe_cell(pfe_next(rp), cp);
    end else begin
      idx = pfe_cell(rp, cq);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/pfe_store.sv =====
// Key square store: cell letters, letter positions, used set and fill count.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
module pfe_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pfe_pkg::pfe_store_req_t req,
  output logic [4:0]             place_q,
  output logic [4:0]             cell_q
);
  import pfe_pkg::*;

  logic [4:0]              square_r [CELLS];
  logic [4:0]              place_r  [LETTER_COUNT];
  logic [LETTER_COUNT-1:0] used_r;
  logic [4:0]              fill_r;
  logic                    place_ok;

  // A letter goes in only if it is a real letter, there is room and it is new.
  assign place_ok = req.place && (req.letter < 5'(LETTER_COUNT)) &&
                    (fill_r < 5'(CELLS)) && !used_r[req.letter];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) square_r[i] <= LETTER_A;
      for (int i = 0; i < LETTER_COUNT; i++) place_r[i] <= 5'd0;
      used_r <= '0;
      fill_r <= 5'd0;
    end else if (place_ok) begin
      square_r[fill_r]     <= req.letter;
      place_r[req.letter]  <= fill_r;
      used_r[req.letter]   <= 1'b1;
      fill_r               <= fill_r + 5'd1;
    end
  end

  assign place_q = place_r[req.place_addr];
  assign cell_q  = square_r[req.cell_addr];

endmodule

// ===== rtl/pfe_ctrl.sv =====
// Sequencer: decodes items, walks the alphabet on key done, and runs the
// four lookups of a pair through the key store. Depends on pfe_pkg.
`timescale 1ns / 1ps
module pfe_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  pfe_pkg::pfe_in_t        in_data,
  output logic                    busy,
  output logic                    out_valid,
  output pfe_pkg::pfe_out_t       out_data,
  output pfe_pkg::pfe_store_req_t req,
  input  logic [4:0]              place_q,
  input  logic [4:0]              cell_q
);
  import pfe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PLACE  = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_LOOK_A = 3'd3;
  localparam logic [2:0] ST_LOOK_B = 3'd4;
  localparam logic [2:0] ST_CELL_A = 3'd5;
  localparam logic [2:0] ST_CELL_B = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [4:0] a_r, a_nxt;
  logic [4:0] b_r, b_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [4:0] pa_r, pa_nxt;
  logic [4:0] pb_r, pb_nxt;
  logic [4:0] ca_r, ca_nxt;
  logic       out_valid_r, out_valid_nxt;
  pfe_out_t   out_r, out_nxt;
  logic [4:0] pair_a;
  logic [4:0] pair_b;

  assign pair_a = pfe_pair_letter(in_data.letter_a);
  assign pair_b = in_data.has_second ? pfe_pair_letter(in_data.letter_b) : LETTER_X;

  always_comb begin
    req.place      = (state_r == ST_PLACE) || ((state_r == ST_FILL) && (cnt_r != LETTER_J));
    req.letter     = (state_r == ST_FILL) ? cnt_r : a_r;
    req.place_addr = (state_r == ST_LOOK_B) ? b_r : a_r;
    // One target unit serves both cipher letters, with the operands swapped.
    req.cell_addr  = pfe_target((state_r == ST_CELL_B) ? pb_r : pa_r,
                                (state_r == ST_CELL_B) ? pa_r : pb_r);
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    ca_nxt        = ca_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.opcode)
            OP_KEY: begin
              a_nxt     = pfe_key_letter(in_data.letter_a);
              state_nxt = ST_PLACE;
            end
            OP_DONE: begin
              cnt_nxt   = LETTER_A;
              state_nxt = ST_FILL;
            end
            OP_PAIR: begin
              a_nxt     = pair_a;
              b_nxt     = (pair_a == pair_b) ? LETTER_X : pair_b;
              state_nxt = ST_LOOK_A;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PLACE: state_nxt = ST_IDLE;
      ST_FILL: begin
        if (cnt_r == LETTER_Z) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_LOOK_A: begin
        pa_nxt    = place_q;
        state_nxt = ST_LOOK_B;
      end
      ST_LOOK_B: begin
        pb_nxt    = place_q;
        state_nxt = ST_CELL_A;
      end
      ST_CELL_A: begin
        ca_nxt    = cell_q;
        state_nxt = ST_CELL_B;
      end
      ST_CELL_B: begin
        out_valid_nxt    = 1'b1;
        out_nxt.cipher_a = ca_r;
        out_nxt.cipher_b = cell_q;
        state_nxt        = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    ca_r  <= ca_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/playfair_cipher_encrypt.sv =====
// Top level of the Playfair 5x5 encryptor: sequencer plus key square store.
// Depends on pfe_pkg, pfe_store and pfe_ctrl.
//
// An item is taken on a rising edge with start high and busy low. A key
// letter keeps busy high for one cycle; key done keeps it high while the
// sequencer walks the alphabet one letter a cycle through the store's
// single placement port, and a pair while it runs two position lookups
// and two cell lookups through the store's one read port each. The cipher
// beat appears on out_data with out_valid high for exactly one cycle, the
// first cycle after busy drops; it cannot be held off, so the receiver must
// take it then. A new item may be started in that same cycle.
`timescale 1ns / 1ps
module playfair_cipher_encrypt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pfe_pkg::pfe_in_t  in_data,
  output logic              busy,
  output logic              out_valid,
  output pfe_pkg::pfe_out_t out_data
);
  import pfe_pkg::*;

  pfe_store_req_t req;
  logic [4:0]     place_q;
  logic [4:0]     cell_q;

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .req       (req),
    .place_q   (place_q),
    .cell_q    (cell_q)
  );

  pfe_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .place_q (place_q),
    .cell_q  (cell_q)
  );

endmodule

// ===== rtl/pfe_checker.sv =====
// Port-level checks for the Playfair encryptor, bound to the top level.
// Depends on pfe_pkg and playfair_cipher_encrypt_defines.svh.
`timescale 1ns / 1ps
`include "playfair_cipher_encrypt_defines.svh"
module pfe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input pfe_pkg::pfe_in_t  in_data,
  input logic              busy,
  input logic              out_valid,
  input pfe_pkg::pfe_out_t out_data
);
  import pfe_pkg::*;

  logic accept_work;
  assign accept_work = start && !busy && (in_data.opcode != OP_NONE);

  // Any real item keeps the block busy in the following cycle.
  `PFE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept_work, busy)
  // A result beat lasts exactly one cycle.
  `PFE_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  // The result beat is shown only once the sequencer is back at rest.
  `PFE_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy)
  // Cipher letters always come from the square, so they are real letters.
  `PFE_ASSERT_NOW(a_cipher_range, clk, rst_n, out_valid,
    (out_data.cipher_a <= LETTER_Z) && (out_data.cipher_b <= LETTER_Z))

endmodule

bind playfair_cipher_encrypt pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_data   (in_data),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== tb/playfair_cipher_encrypt_checker.sv =====
// Checker for the Playfair encryptor: watches the command and cipher beats,
// keeps its own copy of the key square and compares every cipher beat.
// Depends on pfe_pkg for the payload types and letter constants.
`timescale 1ns / 1ps
module playfair_cipher_encrypt_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  pfe_pkg::pfe_in_t  in_data,
  input  logic              out_valid,
  input  pfe_pkg::pfe_out_t out_data,
  output int                errors,
  output int                pending
);
  import pfe_pkg::*;

  logic [4:0]              key_square [CELLS];
  logic [4:0]              cell_of [LETTER_COUNT];
  logic [LETTER_COUNT-1:0] placed;
  int                      cells_filled;
  pfe_out_t                pending_ciphers [$];
  int                      mismatch_total = 0;

  // Plaintext letters: anything past Z reads as X, and J folds onto I.
  function automatic logic [4:0] plain_letter(input logic [4:0] l);
    if (l > LETTER_Z) return LETTER_X;
    if (l == LETTER_J) return LETTER_I;
    return l;
  endfunction

  task automatic add_key_letter(input logic [4:0] l);
    if (l > LETTER_Z || cells_filled >= CELLS || placed[l]) return;
    key_square[cells_filled] = l;
    cell_of[l] = 5'(cells_filled);
    placed[l] = 1'b1;
    cells_filled++;
  endtask

  function automatic pfe_out_t encrypt_pair(input pfe_in_t item);
    logic [4:0] a;
    logic [4:0] b;
    int         ra;
    int         ca;
    int         rb;
    int         cb;
    pfe_out_t   res;
    a = plain_letter(item.letter_a);
    b = item.has_second ? plain_letter(item.letter_b) : LETTER_X;
    if (a == b) b = LETTER_X;
    ra = int'(cell_of[a]) / SIDE;
    ca = int'(cell_of[a]) % SIDE;
    rb = int'(cell_of[b]) / SIDE;
    cb = int'(cell_of[b]) % SIDE;
    if (ra == rb) begin
      res.cipher_a = key_square[ra * SIDE + (ca + 1) % SIDE];
      res.cipher_b = key_square[rb * SIDE + (cb + 1) % SIDE];
    end else if (ca == cb) begin
      res.cipher_a = key_square[((ra + 1) % SIDE) * SIDE + ca];
      res.cipher_b = key_square[((rb + 1) % SIDE) * SIDE + cb];
    end else begin
      res.cipher_a = key_square[ra * SIDE + cb];
      res.cipher_b = key_square[rb * SIDE + ca];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pfe_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < CELLS; k++) key_square[k] = LETTER_A;
      for (int k = 0; k < LETTER_COUNT; k++) cell_of[k] = 5'd0;
      placed = '0;
      cells_filled = 0;
      pending_ciphers.delete();
    end else begin
      // A cipher beat at this edge always belongs to an earlier pair.
      if (out_valid) begin
        if (pending_ciphers.size() == 0) begin
          $error("cipher beat with no pair waiting: cipher_a %0d cipher_b %0d",
                 out_data.cipher_a, out_data.cipher_b);
          mismatch_total++;
        end else begin
          want = pending_ciphers.pop_front();
          if (out_data.cipher_a !== want.cipher_a) begin
            $error("cipher_a mismatch: expected %0d, actual %0d",
                   want.cipher_a, out_data.cipher_a);
            mismatch_total++;
          end
          if (out_data.cipher_b !== want.cipher_b) begin
            $error("cipher_b mismatch: expected %0d, actual %0d",
                   want.cipher_b, out_data.cipher_b);
            mismatch_total++;
          end
        end
      end
      if (start && !busy) begin
        case (in_data.opcode)
          OP_KEY: begin
            add_key_letter((in_data.letter_a == LETTER_J) ? LETTER_I : in_data.letter_a);
          end
          OP_DONE: begin
            for (int l = 0; l < LETTER_COUNT; l++) begin
              if (5'(l) != LETTER_J) add_key_letter(5'(l));
            end
          end
          OP_PAIR: begin
            pending_ciphers.push_back(encrypt_pair(in_data));
          end
          default: begin
          end
        endcase
      end
    end
    pending <= pending_ciphers.size();
    errors <= mismatch_total;
  end

endmodule

// ===== tb/playfair_cipher_encrypt_tb.sv =====
// Top of the Playfair encryptor testbench: clock, reset, command stimulus,
// watchdog and verdict. Depends on pfe_pkg, playfair_cipher_encrypt and
// playfair_cipher_encrypt_checker.
`timescale 1ns / 1ps
module playfair_cipher_encrypt_tb;
  import pfe_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  pfe_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  pfe_out_t out_data;
  int       errors;
  int       pending;
  int       burst_left = 0;
  int       idle_cycles = 0;

  playfair_cipher_encrypt uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  playfair_cipher_encrypt_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic pfe_in_t make_item(input logic [1:0] op, input logic [4:0] a,
                                        input logic [4:0] b, input logic hs);
    pfe_in_t item;
    item.opcode = op;
    item.letter_a = a;
    item.letter_b = b;
    item.has_second = hs;
    return item;
  endfunction

  // Mostly real letters, with J and out-of-range codes mixed in.
  function automatic logic [4:0] rand_letter();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 5'($urandom_range(26, 31));
    if (pick == 1) return LETTER_J;
    return 5'($urandom_range(0, 25));
  endfunction

  // Holds start until the beat is taken, then maybe opens a gap.
  task automatic send(input pfe_in_t item);
    int gap;
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        in_data <= pfe_in_t'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("playfair_cipher_encrypt test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pick;
    int key_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pair on an empty square, then a partial key with ignored letters.
    send(make_item(OP_PAIR, LETTER_A, LETTER_Z, 1'b1));
    send(make_item(OP_KEY, 5'd31, 5'd31, 1'b1));
    send(make_item(OP_KEY, LETTER_J, 5'd0, 1'b0));
    send(make_item(OP_KEY, LETTER_I, 5'd31, 1'b1));
    send(make_item(OP_KEY, LETTER_Z, 5'd12, 1'b0));
    send(make_item(OP_KEY, LETTER_A, 5'd31, 1'b1));
    send(make_item(OP_KEY, 5'd26, 5'd0, 1'b0));
    send(make_item(OP_KEY, LETTER_X, 5'd7, 1'b1));
    send(make_item(OP_PAIR, LETTER_I, LETTER_Z, 1'b1));
    send(make_item(OP_PAIR, LETTER_J, 5'd1, 1'b1));
    send(make_item(OP_PAIR, LETTER_A, 5'd31, 1'b0));
    send(make_item(OP_NONE, 5'd31, 5'd31, 1'b1));

    // Rest of the key at random, pairs read against the partial square.
    key_items = $urandom_range(10, 40);
    for (int n = 0; n < key_items; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        send(make_item(OP_KEY, rand_letter(), 5'($urandom), 1'($urandom)));
      end else if (pick < 18) begin
        send(make_item(OP_PAIR, rand_letter(), rand_letter(), 1'($urandom)));
      end else begin
        send(make_item(OP_NONE, 5'($urandom), 5'($urandom), 1'($urandom)));
      end
    end

    // Complete the square twice, then the pair special cases.
    send(make_item(OP_DONE, 5'd31, 5'd31, 1'b1));
    send(make_item(OP_DONE, 5'd0, 5'd0, 1'b0));
    send(make_item(OP_KEY, 5'd16, 5'd0, 1'b0));
    send(make_item(OP_PAIR, LETTER_X, 5'd0, 1'b0));
    send(make_item(OP_PAIR, LETTER_X, LETTER_X, 1'b1));
    send(make_item(OP_PAIR, 5'd4, 5'd4, 1'b1));
    send(make_item(OP_PAIR, LETTER_J, LETTER_I, 1'b1));
    send(make_item(OP_PAIR, 5'd31, 5'd30, 1'b1));
    send(make_item(OP_PAIR, LETTER_Z, LETTER_A, 1'b1));
    send(make_item(OP_PAIR, LETTER_A, LETTER_Z, 1'b1));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
        send(make_item(OP_PAIR, rand_letter(), rand_letter(), ($urandom_range(0, 7) != 0)));
      end else if (pick == 17) begin
        send(make_item(OP_KEY, rand_letter(), 5'($urandom), 1'($urandom)));
      end else if (pick == 18) begin
        send(make_item(OP_DONE, 5'($urandom), 5'($urandom), 1'($urandom)));
      end else begin
        send(make_item(OP_NONE, 5'($urandom), 5'($urandom), 1'($urandom)));
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("playfair_cipher_encrypt test passed");
    end else begin
      $display("playfair_cipher_encrypt test failed");
    end
    $finish;
  end

endmodule
